### rtl/crd_pkg.sv
// Shared types, constants and the float decode for the CAN receive dispatcher.
// Used by every module under rtl/; depends on nothing.
package crd_pkg;

    localparam int MAX_DATA_BYTES_DEF = 8;

    localparam logic [30:0] ID_THR_A = 31'd692;
    localparam logic [30:0] ID_THR_B = 31'd696;
    localparam logic [30:0] CMD_LO   = 31'd500;
    localparam logic [30:0] CMD_HI   = 31'd600;
    localparam logic [7:0]  TYPE_OK  = 8'd2;
    localparam logic [7:0]  CHAR_C   = 8'h43;
    localparam logic [7:0]  CHAR_R   = 8'h52;

    // Register indexes on the APB port (byte address is 4 * index)
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_PROP    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_MINRATE = 2'd3;

    // Beat positions of the serial header
    localparam int SER_POS_C   = 0;
    localparam int SER_POS_R   = 1;
    localparam int SER_POS_IDH = 2;
    localparam int SER_POS_IDL = 3;
    localparam int SER_POS_DLC = 4;
    localparam int SER_HDR_LEN = 5;

    typedef enum logic [1:0] {
        MODE_THROTTLE = 2'd0,
        MODE_COMMAND  = 2'd1,
        MODE_SERIAL   = 2'd2,
        MODE_IGNORE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_SERIAL  = 2'd1,
        KIND_COMMAND = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  prop_number;
        logic [15:0] timeout_code;
        logic [15:0] min_rate;
    } cfg_t;

    // One queued job: the result kind, the serial payload and a snapshot of
    // the status counters as they stand after this item.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] id_lo;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [15:0] throttle;
        logic [15:0] rate_a;
        logic [15:0] rate_b;
        logic [15:0] rate_total;
        logic [15:0] unknown_ids;
        logic [15:0] bad_types;
    } entry_t;

    // Big-endian single to saturated int32, low 16 bits only.
    function automatic logic [15:0] float_to_s16(input logic [31:0] b);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [31:0] m;
        logic [31:0] mag;
        logic [7:0]  sh;
        logic [15:0] res;
        neg  = b[31];
        ex   = b[30:23];
        frac = b[22:0];
        m    = {8'd0, 1'b1, frac};
        mag  = '0;
        sh   = '0;
        if (ex == 8'hFF && frac != 23'd0) begin
            res = '0;
        end else if (ex < 8'd127) begin
            res = '0;
        end else if (ex >= 8'd158) begin
            res = neg ? 16'h0000 : 16'hFFFF;
        end else begin
            if (ex >= 8'd150) begin
                sh  = ex - 8'd150;
                mag = m << sh[2:0];
            end else begin
                sh  = 8'd150 - ex;
                mag = m >> sh[4:0];
            end
            res = neg ? (16'd0 - mag[15:0]) : mag[15:0];
        end
        return res;
    endfunction

endpackage

### rtl/crd_front.sv
// Front end: accepts input beats, classifies them and updates the counters.
// Pushes one job per beat into the queue; depends on crd_pkg.
module crd_front import crd_pkg::*; #(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // frame_id[30:0], length[34:31], payload[98:35]
    input  logic         s_tuser,   // func
    input  logic         q_full,
    output logic         push,
    output entry_t       push_entry
);

    localparam logic [3:0] DLC_MAX = 4'(MAX_DATA_BYTES);

    logic [15:0] count_a_reg, count_a_next;
    logic [15:0] count_b_reg, count_b_next;
    logic [15:0] rate_a_reg, rate_a_next;
    logic [15:0] rate_b_reg, rate_b_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] thr_reg, thr_next;
    logic [15:0] unk_reg, unk_next;
    logic [15:0] bad_reg, bad_next;

    logic [30:0] frame_id;
    logic [3:0]  length;
    logic [63:0] payload;
    logic [3:0]  dlc;
    logic [16:0] sum;
    logic        accept;
    kind_t       kind;

    assign frame_id = s_tdata[30:0];
    assign length   = s_tdata[34:31];
    assign payload  = s_tdata[98:35];
    assign dlc      = (length > DLC_MAX) ? DLC_MAX : length;
    assign sum      = {1'b0, count_a_reg} + {1'b0, count_b_reg};

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    always_comb begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        rate_a_next  = rate_a_reg;
        rate_b_next  = rate_b_reg;
        total_next   = total_reg;
        thr_next     = thr_reg;
        unk_next     = unk_reg;
        bad_next     = bad_reg;
        kind         = KIND_FRAME;
        if (s_tuser) begin
            rate_a_next  = count_a_reg;
            rate_b_next  = count_b_reg;
            total_next   = sum[16] ? 16'hFFFF : sum[15:0];
            count_a_next = '0;
            count_b_next = '0;
            kind         = KIND_TICK;
        end else begin
            case (cfg.mode)
                MODE_THROTTLE: begin
                    if (frame_id == ID_THR_A || frame_id == ID_THR_B) begin
                        if (frame_id == ID_THR_A) begin
                            if (count_a_reg != 16'hFFFF) count_a_next = count_a_reg + 16'd1;
                        end else begin
                            if (count_b_reg != 16'hFFFF) count_b_next = count_b_reg + 16'd1;
                        end
                        if (payload[15:8] != TYPE_OK) begin
                            if (bad_reg != 16'hFFFF) bad_next = bad_reg + 16'd1;
                        end else begin
                            thr_next = float_to_s16({payload[39:32], payload[47:40],
                                                     payload[55:48], payload[63:56]});
                        end
                    end else begin
                        if (unk_reg != 16'hFFFF) unk_next = unk_reg + 16'd1;
                    end
                end
                MODE_COMMAND: begin
                    if (frame_id >= CMD_LO && frame_id < CMD_HI &&
                        (payload[7:0] == 8'd0 || payload[7:0] == cfg.prop_number)) begin
                        kind = KIND_COMMAND;
                    end
                end
                MODE_SERIAL: begin
                    kind = KIND_SERIAL;
                end
                default: begin
                    kind = KIND_FRAME;
                end
            endcase
        end
    end

    always_comb begin
        push_entry.kind        = kind;
        push_entry.id_lo       = frame_id[15:0];
        push_entry.dlc         = dlc;
        push_entry.payload     = payload;
        push_entry.throttle    = thr_next;
        push_entry.rate_a      = rate_a_next;
        push_entry.rate_b      = rate_b_next;
        push_entry.rate_total  = total_next;
        push_entry.unknown_ids = unk_next;
        push_entry.bad_types   = bad_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            rate_a_reg  <= '0;
            rate_b_reg  <= '0;
            total_reg   <= '0;
            thr_reg     <= '0;
            unk_reg     <= '0;
            bad_reg     <= '0;
        end else if (accept) begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            rate_a_reg  <= rate_a_next;
            rate_b_reg  <= rate_b_next;
            total_reg   <= total_next;
            thr_reg     <= thr_next;
            unk_reg     <= unk_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

### rtl/crd_queue.sv
// Two-entry job queue between the front end and the beat generator.
// Depends on crd_pkg for the job type.
module crd_queue import crd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   head_valid,
    output entry_t head
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/crd_back.sv
// Beat generator: turns queued jobs into output beats, one serial byte per beat.
// Holds the output register; depends on crd_pkg.
module crd_back import crd_pkg::*; #(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         head_valid,
    input  entry_t       head,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    // serial_byte[7:0], throttle_report[23:8], rate_a[39:24], rate_b[55:40],
    // rate_total[71:56], unknown_ids[87:72], bad_types[103:88]
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast
);

    localparam int CNT_W = $clog2(MAX_DATA_BYTES + SER_HDR_LEN);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [103:0]     m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             m_tlast_reg;

    logic             load;
    logic             serial;
    logic             last_beat;
    logic [CNT_W-1:0] byte_idx;
    logic [63:0]      shifted;
    logic [7:0]       sbyte;
    logic [15:0]      report;

    assign serial    = (head.kind == KIND_SERIAL);
    assign last_beat = !serial ||
                       (cnt_reg == CNT_W'(head.dlc) + CNT_W'(SER_HDR_LEN - 1));
    assign load      = head_valid && (!m_tvalid_reg || m_tready);
    assign pop       = load && last_beat;
    assign byte_idx  = cnt_reg - CNT_W'(SER_HDR_LEN);
    assign shifted   = head.payload >> {byte_idx[2:0], 3'b000};
    assign report    = (head.rate_total <= cfg.min_rate) ? cfg.timeout_code : head.throttle;

    always_comb begin
        if (!serial) begin
            sbyte = '0;
        end else begin
            case (cnt_reg)
                CNT_W'(SER_POS_C):   sbyte = CHAR_C;
                CNT_W'(SER_POS_R):   sbyte = CHAR_R;
                CNT_W'(SER_POS_IDH): sbyte = head.id_lo[15:8];
                CNT_W'(SER_POS_IDL): sbyte = head.id_lo[7:0];
                CNT_W'(SER_POS_DLC): sbyte = {4'd0, head.dlc};
                default:             sbyte = shifted[7:0];
            endcase
        end
    end

    always_comb begin
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            cnt_next      = last_beat ? '0 : cnt_reg + CNT_W'(1);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {head.bad_types, head.unknown_ids, head.rate_total,
                            head.rate_b, head.rate_a, report, sbyte};
            m_tuser_reg <= head.kind;
            m_tlast_reg <= last_beat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/can_receive_dispatcher.sv
// Top level of the CAN receive dispatcher: APB registers, front end, job queue
// and beat generator. Depends on crd_pkg, crd_front, crd_queue and crd_back.
//
//   channel   direction  handshake                  payload
//   s_*       in         s_tvalid / s_tready        tdata: id, length, payload; tuser: func
//   m_*       out        m_tvalid / m_tready        tdata: serial_byte .. bad_types;
//                                                   tuser: kind; tlast: last
//   APB       in         psel & penable & pwrite    4 registers at byte addresses 0,4,8,12
//
// The front end takes one input beat per cycle while the two-entry queue has room.
// Ticks, throttle, command and ignored frames give one output beat; a serial frame
// gives 5 + DLC beats (up to 13), one per unstalled cycle, set by crd_back's beat counter.
// Reset is synchronous and active low; it clears the counters, queue and output valid.
// A stalled output holds its beat; the queue lets up to two more inputs in meanwhile.
module can_receive_dispatcher import crd_pkg::*; #(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // frame_id[30:0], length[34:31], payload[98:35]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    // serial_byte[7:0], throttle_report[23:8], rate_a[39:24], rate_b[55:40],
    // rate_total[71:56], unknown_ids[87:72], bad_types[103:88]
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser,    // kind[1:0]
    output logic         m_tlast,    // last
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    mode_t       mode_reg;
    logic [7:0]  prop_reg;
    logic [15:0] timeout_reg;
    logic [15:0] minrate_reg;
    cfg_t        cfg;
    logic        cfg_wr;

    logic        push;
    entry_t      push_entry;
    logic        q_full;
    logic        pop;
    logic        head_valid;
    entry_t      head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_THROTTLE;
            prop_reg    <= '0;
            timeout_reg <= '0;
            minrate_reg <= 16'd2;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:    mode_reg    <= mode_t'(pwdata[1:0]);
                REG_PROP:    prop_reg    <= pwdata[7:0];
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                REG_MINRATE: minrate_reg <= pwdata[15:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:    prdata = {30'd0, mode_reg};
            REG_PROP:    prdata = {24'd0, prop_reg};
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_MINRATE: prdata = {16'd0, minrate_reg};
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        cfg.mode         = mode_reg;
        cfg.prop_number  = prop_reg;
        cfg.timeout_code = timeout_reg;
        cfg.min_rate     = minrate_reg;
    end

    crd_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    crd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    crd_back #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
